FILE: rtl/tsm_pkg.sv
// Shared types, widths and constants of the triangle stiffness block.
package tsm_pkg;

  // Widths of the operands along the datapath
  localparam int COORD_W = 32;            // Q16.16 coordinate
  localparam int DIFF_W  = COORD_W + 1;   // edge term b_i or c_i
  localparam int DM_W    = 32;            // Q8.24 material entry
  localparam int DET_W   = 2 * DIFF_W + 1;
  localparam int ADEN_W  = DET_W + 1;     // |2 det|
  localparam int PROD_W  = DIFF_W + DM_W; // edge term times material entry
  localparam int T_W     = PROD_W + 1;    // sum of two such products
  localparam int AN_W    = 100;           // |N| of one stiffness entry
  localparam int Q_W     = 48;            // quotient bits kept before saturation
  localparam int VAL_W   = 48;            // Q24.24 entry

  localparam int IN_TDATA_W  = 6 * COORD_W;
  localparam int OUT_TDATA_W = 56;
  localparam int CFG_IDX_W   = 3;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_D11 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_D12 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_D13 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_D22 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_D23 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_D33 = 3'd5;

  // Reset values of the material matrix
  localparam logic signed [DM_W-1:0] D11_RST = 32'sd18436501;
  localparam logic signed [DM_W-1:0] D12_RST = 32'sd5530950;
  localparam logic signed [DM_W-1:0] D13_RST = 32'sd0;
  localparam logic signed [DM_W-1:0] D22_RST = 32'sd18436501;
  localparam logic signed [DM_W-1:0] D23_RST = 32'sd0;
  localparam logic signed [DM_W-1:0] D33_RST = 32'sd6452775;

  // Saturation limits of the output format
  localparam logic [VAL_W-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [VAL_W-1:0] NEG_MIN = 48'h8000_0000_0000;

  localparam logic [2:0] LAST_IDX = 3'd5;

  // One triangle, classified and ready for the entry sequencer
  typedef struct packed {
    logic signed [DIFF_W-1:0] b0;
    logic signed [DIFF_W-1:0] b1;
    logic signed [DIFF_W-1:0] b2;
    logic signed [DIFF_W-1:0] c0;
    logic signed [DIFF_W-1:0] c1;
    logic signed [DIFF_W-1:0] c2;
    logic [ADEN_W-1:0]        aden;
    logic                     dneg;
    logic                     degen;
  } job_t;

  // Per-entry tag that rides along the back pipeline
  typedef struct packed {
    logic [2:0] row;
    logic [2:0] col;
    logic       last;
    logic       degen;
    logic       neg;
  } side_t;

endpackage

FILE: rtl/tsm_front.sv
// Front part: takes corner beats, forms edge terms and the determinant.
module tsm_front import tsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic signed [COORD_W-1:0] xa, ya, xb, yb, xc, yc;
  logic                      adv;
  logic                      f1_v_r, f2_v_r, f3_v_r;
  job_t                      f1_r, f2_r, f3_r;
  logic signed [2*DIFF_W-1:0] p1_r, p2_r;
  logic signed [DET_W-1:0]   det_r;
  logic [DET_W-1:0]          absd;

  assign xa = in_tdata[31:0];
  assign ya = in_tdata[63:32];
  assign xb = in_tdata[95:64];
  assign yb = in_tdata[127:96];
  assign xc = in_tdata[159:128];
  assign yc = in_tdata[191:160];

  // whole front moves together; holds when the queue is full
  assign adv       = !f3_v_r || !q_full;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_tvalid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // edge terms b_i = y_j - y_k, c_i = x_k - x_j
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r.b0    <= DIFF_W'(yb) - DIFF_W'(yc);
      f1_r.b1    <= DIFF_W'(yc) - DIFF_W'(ya);
      f1_r.b2    <= DIFF_W'(ya) - DIFF_W'(yb);
      f1_r.c0    <= DIFF_W'(xc) - DIFF_W'(xb);
      f1_r.c1    <= DIFF_W'(xa) - DIFF_W'(xc);
      f1_r.c2    <= DIFF_W'(xb) - DIFF_W'(xa);
      f1_r.aden  <= '0;
      f1_r.dneg  <= 1'b0;
      f1_r.degen <= 1'b0;
      // det = c2*b1 - c1*b2
      f2_r       <= f1_r;
      p1_r       <= f1_r.c2 * f1_r.b1;
      p2_r       <= f1_r.c1 * f1_r.b2;
      f3_r       <= f2_r;
      det_r      <= DET_W'(p1_r) - DET_W'(p2_r);
    end
  end

  // magnitude of 2 det and flags
  assign absd = det_r[DET_W-1] ? DET_W'(-det_r) : DET_W'(det_r);

  always_comb begin
    q_job       = f3_r;
    q_job.aden  = {absd, 1'b0};
    q_job.dneg  = det_r[DET_W-1];
    q_job.degen = (det_r == '0);
  end

  assign q_push = f3_v_r && !q_full;

endmodule

FILE: rtl/tsm_queue.sv
// Two-entry queue of triangle jobs between the front and back parts.
module tsm_queue import tsm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic full,
  output logic empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign head  = mem_r[rd_ptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule

FILE: rtl/tsm_div.sv
// Pipelined restoring divider: one quotient bit per stage, round to nearest.
module tsm_div import tsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_v,
  input  logic [AN_W-1:0]   in_an,
  input  logic [ADEN_W-1:0] in_aden,
  input  side_t             in_side,
  output logic              out_v,
  output logic [Q_W:0]      out_q,
  output logic              out_ovf,
  output side_t             out_side
);

  logic              v_r    [Q_W+1];
  logic [ADEN_W-1:0] r_r    [Q_W+1];
  logic [Q_W-1:0]    low_r  [Q_W+1];
  logic [Q_W-1:0]    quo_r  [Q_W+1];
  logic [ADEN_W-1:0] aden_r [Q_W+1];
  logic              ovf_r  [Q_W+1];
  side_t             side_r [Q_W+1];
  logic              rnd;

  // stage 0: split numerator, flag quotients of 2^48 and above
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[0] <= 1'b0;
    else if (adv) v_r[0] <= in_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r[0]    <= ADEN_W'(in_an[AN_W-1:Q_W]);
      low_r[0]  <= in_an[Q_W-1:0];
      quo_r[0]  <= '0;
      aden_r[0] <= in_aden;
      ovf_r[0]  <= ADEN_W'(in_an[AN_W-1:Q_W]) >= in_aden;
      side_r[0] <= in_side;
    end
  end

  // one shift-compare-subtract per stage
  for (genvar k = 1; k <= Q_W; k++) begin : g_stage
    logic [ADEN_W:0] rs;
    logic            ge;

    assign rs = {r_r[k-1], low_r[k-1][Q_W-1]};
    assign ge = rs >= {1'b0, aden_r[k-1]};

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (adv) v_r[k] <= v_r[k-1];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[k]    <= ge ? ADEN_W'(rs - {1'b0, aden_r[k-1]}) : rs[ADEN_W-1:0];
        low_r[k]  <= {low_r[k-1][Q_W-2:0], 1'b0};
        quo_r[k]  <= {quo_r[k-1][Q_W-2:0], ge};
        aden_r[k] <= aden_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // round half up on the remainder
  assign rnd = {r_r[Q_W], 1'b0} >= {1'b0, aden_r[Q_W]};

  always_ff @(posedge clk) begin
    if (!rst_n) out_v <= 1'b0;
    else if (adv) out_v <= v_r[Q_W];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_q    <= {1'b0, quo_r[Q_W]} + (Q_W+1)'(rnd);
      out_ovf  <= ovf_r[Q_W];
      out_side <= side_r[Q_W];
    end
  end

endmodule

FILE: rtl/tsm_back.sv
// Back part: material registers, entry sequencer, B^T D B datapath, output register.
module tsm_back import tsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DM_W-1:0]        cfg_wdata,
  input  logic                   q_empty,
  input  job_t                   q_job,
  output logic                   q_pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  logic signed [DM_W-1:0] d11_r, d12_r, d13_r, d22_r, d23_r, d33_r;

  logic        adv;
  logic        job_v_r;
  job_t        job_r;
  logic [2:0]  p_r, q_r;
  logic        is_last;

  // stage 1
  logic                     v1_r;
  side_t                    s1_r;
  logic [ADEN_W-1:0]        a1_r;
  logic signed [PROD_W-1:0] pu0_r, pu1_r, pu2_r, pv0_r, pv1_r, pv2_r;
  logic signed [DIFF_W-1:0] w1_r, z1_r;
  logic                     rw1_r;
  logic signed [DIFF_W-1:0] bp, cp, bq, cq, u, v;
  logic                     even_p;
  // stage 2
  logic                     v2_r;
  side_t                    s2_r;
  logic [ADEN_W-1:0]        a2_r;
  logic signed [T_W-1:0]    ta_r, tb_r;
  logic signed [DIFF_W-1:0] w2_r, z2_r;
  // stage 3
  logic                     v3_r;
  side_t                    s3_r;
  logic [ADEN_W-1:0]        a3_r;
  logic signed [55:0]       pa0_r, pa1_r, pb0_r, pb1_r;
  logic signed [54:0]       pa2_r, pb2_r;
  // stage 4
  logic                     v4_r;
  side_t                    s4_r;
  logic [ADEN_W-1:0]        a4_r;
  logic signed [AN_W-1:0]   n_r;
  // stage 5
  logic                     v5_r;
  side_t                    s5_r;
  logic [ADEN_W-1:0]        a5_r;
  logic [AN_W-1:0]          an_r;
  // divider
  logic                     dv_v;
  logic [Q_W:0]             dv_q;
  logic                     dv_ovf;
  side_t                    dv_side;
  // output
  side_t                    o_side_r;
  logic [VAL_W-1:0]         o_val_r;
  logic [VAL_W-1:0]         val_nxt;

  function automatic logic signed [DIFF_W-1:0] sel3(
    input logic signed [DIFF_W-1:0] a0,
    input logic signed [DIFF_W-1:0] a1,
    input logic signed [DIFF_W-1:0] a2,
    input logic [1:0]               idx
  );
    logic signed [DIFF_W-1:0] s;
    unique case (idx)
      2'd0:    s = a0;
      2'd1:    s = a1;
      default: s = a2;
    endcase
    return s;
  endfunction

  // material matrix registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d11_r <= D11_RST;
      d12_r <= D12_RST;
      d13_r <= D13_RST;
      d22_r <= D22_RST;
      d23_r <= D23_RST;
      d33_r <= D33_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_D11: d11_r <= cfg_wdata;
        REG_D12: d12_r <= cfg_wdata;
        REG_D13: d13_r <= cfg_wdata;
        REG_D22: d22_r <= cfg_wdata;
        REG_D23: d23_r <= cfg_wdata;
        REG_D33: d33_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // the whole back pipeline stalls when the output beat is held
  assign adv     = !out_tvalid || out_tready;
  assign is_last = (p_r == LAST_IDX) && (q_r == LAST_IDX);
  assign q_pop   = adv && (!job_v_r || is_last) && !q_empty;

  // entry sequencer: 36 entries per job, row-major
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_v_r <= 1'b0;
      p_r     <= '0;
      q_r     <= '0;
    end else if (adv) begin
      if (!job_v_r || is_last) begin
        job_v_r <= !q_empty;
        p_r     <= '0;
        q_r     <= '0;
      end else if (q_r == LAST_IDX) begin
        q_r <= '0;
        p_r <= p_r + 3'd1;
      end else begin
        q_r <= q_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) job_r <= q_job;
  end

  // column p and column q of B*det
  always_comb begin
    even_p = !p_r[0];
    bp     = sel3(job_r.b0, job_r.b1, job_r.b2, p_r[2:1]);
    cp     = sel3(job_r.c0, job_r.c1, job_r.c2, p_r[2:1]);
    bq     = sel3(job_r.b0, job_r.b1, job_r.b2, q_r[2:1]);
    cq     = sel3(job_r.c0, job_r.c1, job_r.c2, q_r[2:1]);
    u      = even_p ? bp : cp;
    v      = even_p ? cp : bp;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (adv) begin
      v1_r <= job_v_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // stages 1 to 5: t = B_p^T D, N = t . B_q, then |N|
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r.row   <= p_r;
      s1_r.col   <= q_r;
      s1_r.last  <= is_last;
      s1_r.degen <= job_r.degen;
      s1_r.neg   <= job_r.dneg;
      a1_r       <= job_r.aden;
      pu0_r      <= u * (even_p ? d11_r : d12_r);
      pu1_r      <= u * (even_p ? d12_r : d22_r);
      pu2_r      <= u * (even_p ? d13_r : d23_r);
      pv0_r      <= v * d13_r;
      pv1_r      <= v * d23_r;
      pv2_r      <= v * d33_r;
      w1_r       <= q_r[0] ? cq : bq;
      z1_r       <= q_r[0] ? bq : cq;
      rw1_r      <= q_r[0];

      s2_r <= s1_r;
      a2_r <= a1_r;
      ta_r <= rw1_r ? T_W'(pu1_r) + T_W'(pv1_r) : T_W'(pu0_r) + T_W'(pv0_r);
      tb_r <= T_W'(pu2_r) + T_W'(pv2_r);
      w2_r <= w1_r;
      z2_r <= z1_r;

      s3_r  <= s2_r;
      a3_r  <= a2_r;
      pa0_r <= $signed({1'b0, ta_r[21:0]}) * w2_r;
      pa1_r <= $signed({1'b0, ta_r[43:22]}) * w2_r;
      pa2_r <= $signed(ta_r[65:44]) * w2_r;
      pb0_r <= $signed({1'b0, tb_r[21:0]}) * z2_r;
      pb1_r <= $signed({1'b0, tb_r[43:22]}) * z2_r;
      pb2_r <= $signed(tb_r[65:44]) * z2_r;

      s4_r <= s3_r;
      a4_r <= a3_r;
      n_r  <= (AN_W'(pa2_r) <<< 44) + (AN_W'(pa1_r) <<< 22) + AN_W'(pa0_r)
            + (AN_W'(pb2_r) <<< 44) + (AN_W'(pb1_r) <<< 22) + AN_W'(pb0_r);

      s5_r.row   <= s4_r.row;
      s5_r.col   <= s4_r.col;
      s5_r.last  <= s4_r.last;
      s5_r.degen <= s4_r.degen;
      s5_r.neg   <= s4_r.neg ^ n_r[AN_W-1];
      a5_r       <= a4_r;
      an_r       <= n_r[AN_W-1] ? AN_W'(-n_r) : AN_W'(n_r);
    end
  end

  tsm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_v     (v5_r),
    .in_an    (an_r),
    .in_aden  (a5_r),
    .in_side  (s5_r),
    .out_v    (dv_v),
    .out_q    (dv_q),
    .out_ovf  (dv_ovf),
    .out_side (dv_side)
  );

  // sign and saturation
  always_comb begin
    if (dv_side.degen) begin
      val_nxt = '0;
    end else if (dv_side.neg) begin
      if (dv_ovf || dv_q > {1'b0, NEG_MIN}) val_nxt = NEG_MIN;
      else                                  val_nxt = VAL_W'((Q_W+1)'(0) - dv_q);
    end else begin
      if (dv_ovf || dv_q > {1'b0, POS_MAX}) val_nxt = POS_MAX;
      else                                  val_nxt = dv_q[VAL_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_tvalid <= 1'b0;
    else if (adv) out_tvalid <= dv_v;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_side_r <= dv_side;
      o_val_r  <= val_nxt;
    end
  end

  assign out_tdata = {2'b00, o_val_r, o_side_r.col, o_side_r.row};
  assign out_tuser = o_side_r.degen;
  assign out_tlast = o_side_r.last;

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_side_r.degen |-> o_val_r == '0)
    else $error("degenerate entry not zero");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o_side_r.last |-> o_side_r.row == LAST_IDX && o_side_r.col == LAST_IDX)
    else $error("last flag away from final entry");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("job taken from empty queue");

endmodule

FILE: rtl/triangle_stiffness_matrix_top.sv
// Top level of the constant-strain triangle stiffness block.
//
// One input beat carries the three corners of a triangle (Q16.16); the block
// returns the 36 entries of its 6x6 stiffness matrix B^T D B * det/2 in
// row-major order, Q24.24, rounded to nearest and saturated, tlast on entry
// (5,5). A zero determinant yields 36 zero entries with tuser (degenerate)
// set. A clockwise triangle gives the negated matrix. Entries leave at one
// per cycle while jobs are waiting and out_tready is high; the whole back
// part stalls when out_tready is low. The front part takes a new triangle
// while the back part is still emitting, with a two-deep job queue between
// them. Latency from input beat to first entry is set mostly by the pipelined
// divider. The user must write the material registers by cfg_we/cfg_index
// only while the block is idle; the block itself does not enforce this.
module triangle_stiffness_matrix_top import tsm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  // in_tdata: xa, ya, xb, yb, xc, yc (32 bits each, from bit 0 up)
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: row_index[2:0], col_index[5:3], entry_value[53:6], zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // out_tuser: degenerate
  output logic                   out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [DM_W-1:0]        cfg_wdata
);

  logic q_push, q_pop, q_full, q_empty;
  job_t push_job, head_job;

  tsm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  tsm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head     (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  tsm_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .q_empty    (q_empty),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
